/* hdl/median_filter_3x3_rgb_macros.svh */
// assertion macros for the 3x3 median filter
// no dependencies
`ifndef MEDIAN_FILTER_3X3_RGB_MACROS_SVH
`define MEDIAN_FILTER_3X3_RGB_MACROS_SVH
// assert that a implies b in the next cycle
`define MF_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("mf check failed");
// assert that a implies b in the same cycle
`define MF_ASSERT_SAME(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("mf check failed");
`endif

/* hdl/mf3_pkg.sv */
// shared types, register indexes and the median function of the 3x3 median filter
// no dependencies
package mf3_pkg;
	localparam int unsigned REG_WIDTH = 0;
	localparam int unsigned REG_HEIGHT = 1;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	typedef logic [23:0] rgb_t;

	// one channel value plus a flag that marks it as in use
	typedef struct packed {
		logic       use_c;
		logic [7:0] val;
	} chv_t;

	// rank-based selection: value whose rank among used values equals n/2
	function automatic logic [7:0] med9(input chv_t [8:0] v);
		logic [3:0] n;
		logic [3:0] lt;
		logic [3:0] le;
		logic [3:0] k;
		logic [7:0] r;
		n = '0;
		r = '0;
		for (int i = 0; i < 9; i++) n = n + {3'd0, v[i].use_c};
		k = n >> 1;
		for (int i = 0; i < 9; i++) begin
			lt = '0;
			le = '0;
			for (int j = 0; j < 9; j++) begin
				if (v[j].use_c && v[j].val < v[i].val) lt = lt + 4'd1;
				if (v[j].use_c && v[j].val <= v[i].val) le = le + 4'd1;
			end
			if (v[i].use_c && lt <= k && k < le) r = v[i].val;
		end
		return r;
	endfunction
endpackage

/* hdl/mf3_median.sv */
// registered per-channel median over a masked 3x3 window
// depends on mf3_pkg
module mf3_median (
	input  logic               clk,
	input  logic               en,
	input  mf3_pkg::rgb_t [8:0] win,
	input  logic [8:0]         mask,
	output mf3_pkg::rgb_t      med
);
	import mf3_pkg::*;
	chv_t [8:0] r, g, b;
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			r[i] = '{use_c: mask[i], val: win[i][23:16]};
			g[i] = '{use_c: mask[i], val: win[i][15:8]};
			b[i] = '{use_c: mask[i], val: win[i][7:0]};
		end
	end
	always_ff @(posedge clk) begin
		if (en) med <= {med9(r), med9(g), med9(b)};
	end
endmodule

/* hdl/median_filter_3x3_rgb.sv */
// 3x3 per-channel median filter: two line memories read in stage 1, window in stage 2,
// median in stage 3.
// throughput: one request per cycle while the output is not held; a result appears width+1 requests after its pixel.
// reset clears counters and pipeline valids; line memories are not cleared.
// depends on mf3_pkg, mf3_median and median_filter_3x3_rgb_macros.svh
`include "median_filter_3x3_rgb_macros.svh"
module median_filter_3x3_rgb #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] pixel_argb,
	input  logic        is_padding,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] filtered_argb,
	output logic        last_of_frame
);
	import mf3_pkg::*;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam int LW = CW + 1;

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [CW:0] w_eff;
	logic [RW:0] h_eff;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd640;
			height_q <= 13'd480;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				1'(REG_WIDTH):  width_q <= pwdata[10:0];
				1'(REG_HEIGHT): height_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			1'(REG_WIDTH):  prdata = {21'd0, width_q};
			1'(REG_HEIGHT): prdata = {19'd0, height_q};
			default: ;
		endcase
	end
	always_comb begin
		if (width_q == '0) w_eff = (CW+1)'(1);
		else if (32'(width_q) > MAX_WIDTH) w_eff = (CW+1)'(MAX_WIDTH);
		else w_eff = (CW+1)'(width_q);
		if (height_q == '0) h_eff = (RW+1)'(1);
		else if (32'(height_q) > MAX_HEIGHT) h_eff = (RW+1)'(MAX_HEIGHT);
		else h_eff = (RW+1)'(height_q);
	end

	// pipeline advance: stalls only when the output register is held
	logic v_s1, v_s2, v_s3;
	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;
	logic acc;
	assign acc = in_valid && adv;

	// counters
	logic [CW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] out_row_q;
	logic [LW-1:0] lead_q;
	logic emit;
	logic [CW-1:0] col_n;
	logic [CW:0] out_col_p1;
	logic [RW:0] out_row_p1;
	logic last;
	assign emit = (LW+1)'(lead_q) >= (LW+1)'(w_eff) + (LW+1)'(1);
	assign out_col_p1 = {1'b0, out_col_q} + 1'b1;
	assign out_row_p1 = {1'b0, out_row_q} + 1'b1;
	assign last = emit && out_col_p1 >= w_eff && out_row_p1 >= h_eff;
	assign col_n = ({1'b0, in_col_q} + 1'b1 >= w_eff) ? '0 : in_col_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			lead_q <= '0;
		end else if (acc) begin
			if (last) begin
				in_col_q <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				lead_q <= '0;
			end else begin
				in_col_q <= col_n;
				if (!emit) lead_q <= lead_q + 1'b1;
				else if (out_col_p1 >= w_eff) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 1'b1;
				end else out_col_q <= out_col_q + 1'b1;
			end
		end
	end

	// stage 1: read line memories; the same column repeats back to back only when width
	// is 1 or across the end of a frame, handled by forwarding
	rgb_t mem_a [MAX_WIDTH];
	rgb_t mem_b [MAX_WIDTH];
	rgb_t rd_a, rd_b, pix_s1;
	logic [CW-1:0] x_s1;
	logic emit_s1, last_s1;
	logic [8:0] mask_s1;
	logic fwd_s1;
	rgb_t pix_in;
	assign pix_in = is_padding ? '0 : pixel_argb[23:0];

	logic [8:0] mask_n;
	always_comb begin
		logic lft, rgt, top, bot;
		lft = out_col_q != '0;
		rgt = !(out_col_p1 >= w_eff);
		top = out_row_q != '0;
		bot = !(out_row_p1 >= h_eff);
		for (int c = 0; c < 3; c++)
			for (int r = 0; r < 3; r++)
				mask_n[c*3+r] = (c != 0 || lft) && (c != 2 || rgt) &&
					(r != 0 || top) && (r != 2 || bot);
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_a <= mem_a[in_col_q];
			rd_b <= mem_b[in_col_q];
		end
	end
	// line memory writes happen in stage 2 once the read data is known
	rgb_t up1_s2, pix_s2;
	rgb_t up1, up2;
	assign up1 = fwd_s1 ? pix_s2 : rd_a;
	assign up2 = fwd_s1 ? up1_s2 : rd_b;
	always_ff @(posedge clk) begin
		if (v_s1 && adv) begin
			mem_a[x_s1] <= pix_s1;
			mem_b[x_s1] <= up1;
		end
	end

	rgb_t [8:0] win_q;
	logic last_s2;
	logic [8:0] mask_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1 && emit_s1;
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			if (acc) begin
				pix_s1 <= pix_in;
				x_s1 <= in_col_q;
				emit_s1 <= emit;
				last_s1 <= last;
				mask_s1 <= mask_n;
				fwd_s1 <= v_s1 && x_s1 == in_col_q;
			end
			if (v_s1) begin
				win_q <= {pix_s1, up1, up2, win_q[8:3]};
				up1_s2 <= up1;
				pix_s2 <= pix_s1;
			end
			last_s2 <= last_s1;
			mask_s2 <= mask_s1;
		end
	end

	rgb_t med;
	logic last_s3;
	mf3_median u_med (.clk(clk), .en(adv && v_s2), .win(win_q), .mask(mask_s2), .med(med));
	always_ff @(posedge clk) begin
		if (adv && v_s2) last_s3 <= last_s2;
	end
	assign out_valid = v_s3;
	assign filtered_argb = {ALPHA_OPAQUE, med};
	assign last_of_frame = last_s3;

	`MF_ASSERT_SAME(a_stall, out_valid && out_stall, in_stall)
	`MF_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(filtered_argb))
	`MF_ASSERT_NEXT(a_last_clr, acc && last, lead_q == '0 && in_col_q == '0)
endmodule
